>>> rtl/clpe_pkg.sv
// Package with shared types, constants and codes of the line position estimator.
package clpe_pkg;
    localparam int MAX_SENSORS = 16;
    localparam int CAL_ROUNDS  = 10;
    localparam int IDX_W       = $clog2(MAX_SENSORS);

    localparam logic [1:0] KIND_RESET = 2'd0;
    localparam logic [1:0] KIND_CAL   = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_WHITE   = 2'd2;

    localparam logic [9:0] FULL_SCALE  = 10'd1000;
    localparam logic [9:0] THRESH_KEEP = 10'd800;
    localparam logic [9:0] THRESH_SEEN = 10'd200;
    localparam logic [9:0] THRESH_SUM  = 10'd50;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] raw_time;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  sensor_index;
        logic [9:0]  calibrated_value;
        logic        frame_done;
        logic [13:0] line_position;
        logic        line_seen;
        logic        is_calibrated;
    } out_item_t;
endpackage

>>> rtl/clpe_div.sv
// Shared restoring divider, one quotient bit per cycle, 28-bit dividend and 16-bit divisor.
module clpe_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [27:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [27:0] quotient
);
    logic [27:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;

    assign trial    = {rem_reg, quo_reg[27]};
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                cnt_reg  <= 5'd27;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // The remainder stays below the divisor, so 16 bits hold it.
                if (trial >= {1'b0, dsr_reg})
                begin
                    rem_reg <= 16'(trial - {1'b0, dsr_reg});
                    quo_reg <= {quo_reg[26:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[15:0];
                    quo_reg <= {quo_reg[26:0], 1'b0};
                end
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end
endmodule

>>> rtl/calibrated_line_position_estimator.sv
// Top level of the calibrated line position estimator.
// One item is taken at a time, and in_stall stays high until it is finished; after reset the
// block first clears the calibration. A calibration sample updates the sensor's extremes, and
// after the last calibration round these extremes are folded into the calibration one sensor
// a cycle, for as many sensors as the sensor count. A reset of the calibration walks every
// sensor entry. A line sample runs the scaling division on the shared 28-step divider, unless
// its value is zero without a division (no calibration yet, a zero span, or a time at or below
// the calibrated minimum). The last sensor of a frame runs the position division on the same
// divider when a line was seen. Results wait in an output register, and a result held by
// out_stall holds the next one, and with it the input, for as long.
module calibrated_line_position_estimator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  clpe_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output clpe_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import clpe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CAL, S_COMMIT, S_LINE, S_SDIV, S_SWAIT, S_ACC, S_PDIV, S_PWAIT,
        S_OUT
    } state_t;

    state_t      state_reg;
    logic [15:0] timeout_reg;
    logic [4:0]  count_reg;
    logic        white_reg;
    logic [15:0] cal_min_reg [MAX_SENSORS];
    logic [15:0] cal_max_reg [MAX_SENSORS];
    logic [15:0] rmin_reg [MAX_SENSORS];
    logic [15:0] rmax_reg [MAX_SENSORS];
    logic [3:0]  round_reg;
    logic [IDX_W-1:0] cursor_reg;
    logic        calflag_reg;
    logic [13:0] lastpos_reg;
    logic [27:0] wtot_reg;
    logic [13:0] vtot_reg;
    logic        seen_reg;
    logic [IDX_W:0] walk_reg;
    logic [15:0] raw_reg;
    logic        last_reg;
    logic [9:0]  x_reg;
    out_item_t   res_reg;
    out_item_t   out_reg;
    logic        ovalid_reg;
    logic        ovalid_next;

    logic        div_start;
    logic        div_done;
    logic [27:0] div_q;
    logic [27:0] div_a;
    logic [15:0] div_b;

    logic [4:0]  ecount;
    logic [15:0] lo, den;
    logic [9:0]  v;
    logic [13:0] span;
    logic [IDX_W-1:0] walk_idx;

    assign ecount   = (count_reg == 5'd0) ? 5'd1 :
                      (count_reg > 5'(MAX_SENSORS)) ? 5'(MAX_SENSORS) : count_reg;
    assign lo       = cal_min_reg[cursor_reg];
    assign den      = cal_max_reg[cursor_reg] - lo;
    assign v        = white_reg ? FULL_SCALE - x_reg : x_reg;
    assign span     = 14'(({9'd0, ecount} - 14'd1) * 14'd1000);
    assign walk_idx = walk_reg[IDX_W-1:0];
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_COUNT:   prdata = {27'd0, count_reg};
            REG_WHITE:   prdata = {31'd0, white_reg};
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg && out_stall;
        if (state_reg == S_OUT && (!ovalid_reg || !out_stall))
            ovalid_next = 1'b1;
    end

    always_comb
    begin
        div_start = (state_reg == S_SDIV) || (state_reg == S_PDIV);
        if (state_reg == S_PDIV)
        begin
            div_a = wtot_reg;
            div_b = {2'd0, vtot_reg};
        end
        else
        begin
            div_a = 28'(({12'd0, raw_reg} - {12'd0, lo}) * 28'd1000);
            div_b = den;
        end
    end

    clpe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            timeout_reg <= 16'd2500;
            count_reg   <= 5'd12;
            white_reg   <= 1'b0;
            round_reg   <= '0;
            cursor_reg  <= '0;
            calflag_reg <= 1'b0;
            lastpos_reg <= '0;
            wtot_reg    <= '0;
            vtot_reg    <= '0;
            seen_reg    <= 1'b0;
            walk_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                    REG_COUNT:   count_reg   <= pwdata[4:0];
                    REG_WHITE:   white_reg   <= pwdata[0];
                    default:     ;
                endcase
            end
            ovalid_reg <= ovalid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        raw_reg  <= (in_data.raw_time > timeout_reg) ? timeout_reg
                                                                     : in_data.raw_time;
                        last_reg <= ({1'b0, cursor_reg} + 5'd1 >= ecount);
                        walk_reg <= '0;
                        priority case (in_data.kind)
                            KIND_RESET: state_reg <= S_CLR;
                            KIND_CAL:   state_reg <= S_CAL;
                            KIND_LINE:  state_reg <= S_LINE;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CLR:
                begin
                    // Walks every entry; also used right after reset.
                    cal_min_reg[walk_idx] <= timeout_reg;
                    cal_max_reg[walk_idx] <= '0;
                    walk_reg <= walk_reg + 1'b1;
                    if (walk_idx == IDX_W'(MAX_SENSORS - 1))
                    begin
                        round_reg  <= '0;
                        cursor_reg <= '0;
                        wtot_reg   <= '0;
                        vtot_reg   <= '0;
                        seen_reg   <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                S_CAL:
                begin
                    if (round_reg == 4'd0 || raw_reg < rmin_reg[cursor_reg])
                        rmin_reg[cursor_reg] <= raw_reg;
                    if (round_reg == 4'd0 || raw_reg > rmax_reg[cursor_reg])
                        rmax_reg[cursor_reg] <= raw_reg;
                    if (last_reg)
                    begin
                        cursor_reg <= '0;
                        wtot_reg   <= '0;
                        vtot_reg   <= '0;
                        seen_reg   <= 1'b0;
                        if (round_reg + 4'd1 >= 4'(CAL_ROUNDS))
                        begin
                            round_reg <= '0;
                            state_reg <= S_COMMIT;
                        end
                        else
                        begin
                            round_reg <= round_reg + 4'd1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        cursor_reg <= cursor_reg + 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_COMMIT:
                begin
                    if (rmin_reg[walk_idx] > cal_max_reg[walk_idx])
                        cal_max_reg[walk_idx] <= rmin_reg[walk_idx];
                    if (rmax_reg[walk_idx] < cal_min_reg[walk_idx])
                        cal_min_reg[walk_idx] <= rmax_reg[walk_idx];
                    walk_reg <= walk_reg + 1'b1;
                    if (walk_reg + 1'b1 >= ecount)
                    begin
                        calflag_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_LINE:
                begin
                    if (!calflag_reg || den == 16'd0 || raw_reg <= lo)
                    begin
                        x_reg     <= '0;
                        state_reg <= S_ACC;
                    end
                    else
                        state_reg <= S_SDIV;
                end
                S_SDIV:
                    state_reg <= S_SWAIT;
                S_SWAIT:
                begin
                    if (div_done)
                    begin
                        if (div_q > 28'd1000)
                            x_reg <= FULL_SCALE;
                        else if (div_q < 28'(THRESH_KEEP))
                            x_reg <= '0;
                        else
                            x_reg <= div_q[9:0];
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    res_reg.sensor_index     <= 4'(cursor_reg);
                    res_reg.calibrated_value <= x_reg;
                    res_reg.frame_done       <= last_reg;
                    res_reg.line_position    <= '0;
                    res_reg.line_seen        <= 1'b0;
                    res_reg.is_calibrated    <= calflag_reg;
                    if (v > THRESH_SEEN)
                        seen_reg <= 1'b1;
                    if (v > THRESH_SUM)
                    begin
                        // The product v*1000 fits in 20 bits; it is then multiplied by the sensor index.
                        wtot_reg <= wtot_reg + 28'(({18'd0, v} * 28'd1000) * cursor_reg);
                        vtot_reg <= vtot_reg + {4'd0, v};
                    end
                    if (last_reg)
                        state_reg <= S_PDIV;
                    else
                    begin
                        cursor_reg <= cursor_reg + 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_PDIV:
                begin
                    res_reg.line_seen <= seen_reg;
                    if (seen_reg && vtot_reg != 14'd0)
                        state_reg <= S_PWAIT;
                    else
                    begin
                        res_reg.line_position <= (lastpos_reg < {1'b0, span[13:1]}) ? 14'd0
                                                                                     : span;
                        cursor_reg <= '0;
                        wtot_reg   <= '0;
                        vtot_reg   <= '0;
                        seen_reg   <= 1'b0;
                        state_reg  <= S_OUT;
                    end
                end
                S_PWAIT:
                begin
                    if (div_done)
                    begin
                        lastpos_reg           <= div_q[13:0];
                        res_reg.line_position <= div_q[13:0];
                        cursor_reg <= '0;
                        wtot_reg   <= '0;
                        vtot_reg   <= '0;
                        seen_reg   <= 1'b0;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // The finished result moves out only once the previous transfer is gone.
                    if (!ovalid_reg || !out_stall)
                    begin
                        out_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
